>>> rtl/core/crcl_pkg.sv
// ----------------------------------------------------------------------------
// crcl_pkg: shared types and helpers of the CRC framed log record writer
// Holds the command record passed from the front to the back part, the
// address and CRC widths, and the byte-wise CRC-16/CCITT-FALSE update.
// ----------------------------------------------------------------------------
`default_nettype none

package crcl_pkg;

  localparam int unsigned AddrW      = 11;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CrcW       = 16;
  localparam int unsigned LenW       = 6;
  localparam int unsigned CountW     = 6;
  localparam int unsigned TextCapMax = 61;
  localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;

  // Command queue depth
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;
  localparam int unsigned QueueCntW  = 3;

  // One request from the front part: every write one input item causes
  typedef struct packed {
    logic             erase;       // clear byte 0 of every slot first
    logic             text;        // write one text byte
    logic [AddrW-1:0] text_addr;
    logic [ByteW-1:0] text_byte;
    logic             close;       // write NUL and CRC high/low bytes
    logic [AddrW-1:0] close_addr;  // address of the NUL
    logic [CrcW-1:0]  crc;
  } cmd_t;

  // Byte-wise CRC-16/CCITT-FALSE update (polynomial 0x1021, no reflection)
  function automatic logic [CrcW-1:0] crc_update(input logic [CrcW-1:0]  crc,
                                                 input logic [ByteW-1:0] b);
    logic [ByteW-1:0] x;
    logic [CrcW-1:0]  xw;
    x  = crc[15:8] ^ b;
    x  = x ^ (x >> 4);
    xw = {8'h00, x};
    return {crc[7:0], 8'h00} ^ (xw << 12) ^ (xw << 5) ^ xw;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/crcl_front.sv
// ----------------------------------------------------------------------------
// crcl_front: message byte classifier
// Accepts one message byte per cycle while the queue has room, tracks the
// record state and running CRC, and issues a command per item that writes.
// ----------------------------------------------------------------------------
`default_nettype none

module crcl_front #(
  parameter int unsigned SLOT_BYTES = 64,
  parameter int unsigned SLOT_COUNT = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [crcl_pkg::ByteW-1:0]      msg_byte_i,
  input  wire logic                            msg_end_i,
  output logic                                 push_o,
  output crcl_pkg::cmd_t                       cmd_o,
  input  wire logic                            full_i
);

  localparam int unsigned Room    = SLOT_BYTES - 3;
  localparam int unsigned TextCap = (Room < crcl_pkg::TextCapMax) ? Room
                                                                  : crcl_pkg::TextCapMax;

  logic [crcl_pkg::CountW-1:0] count_q, count_d, count_eff;
  logic [crcl_pkg::AddrW-1:0]  base_q, base_d, base_eff;
  logic [crcl_pkg::CrcW-1:0]   crc_q, crc_d, crc_eff, crc_text, crc_close;
  logic [crcl_pkg::LenW-1:0]   len_q, len_d, len_eff, len_text;
  logic                        in_msg_q, in_msg_d;
  logic                        ended_q, ended_d, ended_eff;
  logic                        accept, first, erase, keep, zero_end, close;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Classify the byte against the record state
  always_comb begin
    first     = !in_msg_q;
    erase     = first && (count_q >= crcl_pkg::CountW'(SLOT_COUNT));
    count_eff = erase ? '0 : count_q;
    base_eff  = erase ? '0 : base_q;
    crc_eff   = first ? crcl_pkg::CrcInit : crc_q;
    len_eff   = first ? '0 : len_q;
    ended_eff = first ? 1'b0 : ended_q;

    zero_end  = !ended_eff && (msg_byte_i == '0);
    keep      = !ended_eff && (msg_byte_i != '0) &&
                (len_eff < crcl_pkg::LenW'(TextCap));
    crc_text  = keep ? crcl_pkg::crc_update(crc_eff, msg_byte_i) : crc_eff;
    len_text  = len_eff + crcl_pkg::LenW'(keep);
    close     = msg_end_i && (len_text != '0);
    crc_close = crcl_pkg::crc_update(crc_text, '0);

    cmd_o.erase      = erase;
    cmd_o.text       = keep;
    cmd_o.text_addr  = base_eff + crcl_pkg::AddrW'(len_eff);
    cmd_o.text_byte  = msg_byte_i;
    cmd_o.close      = close;
    cmd_o.close_addr = base_eff + crcl_pkg::AddrW'(len_text);
    cmd_o.crc        = crc_close;
    push_o           = accept && (erase || keep || close);

    // Next record state
    if (msg_end_i) begin
      in_msg_d = 1'b0;
      ended_d  = 1'b0;
      len_d    = '0;
      crc_d    = crcl_pkg::CrcInit;
      count_d  = close ? count_eff + crcl_pkg::CountW'(1) : count_eff;
      base_d   = close ? base_eff + crcl_pkg::AddrW'(SLOT_BYTES) : base_eff;
    end else begin
      in_msg_d = 1'b1;
      ended_d  = ended_eff || zero_end;
      len_d    = len_text;
      crc_d    = crc_text;
      count_d  = count_eff;
      base_d   = base_eff;
    end
  end

  // Hold record state; advance on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      base_q   <= '0;
      crc_q    <= crcl_pkg::CrcInit;
      len_q    <= '0;
      in_msg_q <= 1'b0;
      ended_q  <= 1'b0;
    end else if (accept) begin
      count_q  <= count_d;
      base_q   <= base_d;
      crc_q    <= crc_d;
      len_q    <= len_d;
      in_msg_q <= in_msg_d;
      ended_q  <= ended_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/crcl_queue.sv
// ----------------------------------------------------------------------------
// crcl_queue: command queue
// Short first-in first-out buffer of command requests between the front
// and the back part, so that each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module crcl_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  crcl_pkg::cmd_t      cmd_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output crcl_pkg::cmd_t      head_o,
  output logic                avail_o
);

  crcl_pkg::cmd_t                   mem_q [crcl_pkg::QueueDepth];
  logic [crcl_pkg::QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [crcl_pkg::QueueCntW-1:0]   cnt_q;
  logic                             do_push, do_pop;

  assign full_o  = (cnt_q == crcl_pkg::QueueCntW'(crcl_pkg::QueueDepth));
  assign avail_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && avail_o;

  // Store requests
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + crcl_pkg::QueuePtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + crcl_pkg::QueuePtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + crcl_pkg::QueueCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - crcl_pkg::QueueCntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/crcl_back.sv
// ----------------------------------------------------------------------------
// crcl_back: memory write sequencer
// Expands the head command request into its erase, text and record-close
// writes, one per cycle unless stalled, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module crcl_back #(
  parameter int unsigned SLOT_BYTES = 64,
  parameter int unsigned SLOT_COUNT = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  crcl_pkg::cmd_t                     head_i,
  input  wire logic                          avail_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [crcl_pkg::AddrW-1:0]         wr_address_o,
  output logic [crcl_pkg::ByteW-1:0]         wr_byte_o,
  output logic                               is_erase_o,
  output logic                               run_last_o
);

  localparam int unsigned EraseIdxW = $clog2(SLOT_COUNT + 1);
  localparam logic [1:0]  CloseLast = 2'd2;

  typedef enum logic [1:0] {
    BEAT_ERASE,
    BEAT_TEXT,
    BEAT_CLOSE
  } beat_e;

  beat_e                       beat;
  logic                        erase_done_q, text_done_q;
  logic [EraseIdxW-1:0]        erase_idx_q;
  logic [crcl_pkg::AddrW-1:0]  erase_addr_q;
  logic [1:0]                  close_idx_q;
  logic                        erase_tail, last, load, step;
  logic [crcl_pkg::AddrW-1:0]  addr;
  logic [crcl_pkg::ByteW-1:0]  data;

  logic                        out_valid_q;
  logic [crcl_pkg::AddrW-1:0]  out_addr_q;
  logic [crcl_pkg::ByteW-1:0]  out_byte_q;
  logic                        out_erase_q, out_last_q;

  assign erase_tail = (erase_idx_q == EraseIdxW'(SLOT_COUNT - 1));

  // Pick the next write of the head request
  always_comb begin
    if (head_i.erase && !erase_done_q) begin
      beat = BEAT_ERASE;
    end else if (head_i.text && !text_done_q) begin
      beat = BEAT_TEXT;
    end else begin
      beat = BEAT_CLOSE;
    end

    case (beat)
      BEAT_ERASE: begin
        addr = erase_addr_q;
        data = '0;
        last = erase_tail && !head_i.text && !head_i.close;
      end
      BEAT_TEXT: begin
        addr = head_i.text_addr;
        data = head_i.text_byte;
        last = !head_i.close;
      end
      default: begin
        addr = head_i.close_addr + crcl_pkg::AddrW'(close_idx_q);
        case (close_idx_q)
          2'd0:    data = '0;
          2'd1:    data = head_i.crc[15:8];
          default: data = head_i.crc[7:0];
        endcase
        last = (close_idx_q == CloseLast);
      end
    endcase
  end

  assign load  = !out_valid_q || out_ready_i;
  assign step  = load && avail_i;
  assign pop_o = step && last;

  // Track progress through the head request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      erase_done_q <= 1'b0;
      erase_idx_q  <= '0;
      erase_addr_q <= '0;
      text_done_q  <= 1'b0;
      close_idx_q  <= '0;
    end else if (step) begin
      if (last) begin
        erase_done_q <= 1'b0;
        erase_idx_q  <= '0;
        erase_addr_q <= '0;
        text_done_q  <= 1'b0;
        close_idx_q  <= '0;
      end else begin
        case (beat)
          BEAT_ERASE: begin
            if (erase_tail) begin
              erase_done_q <= 1'b1;
              erase_idx_q  <= '0;
              erase_addr_q <= '0;
            end else begin
              erase_idx_q  <= erase_idx_q + EraseIdxW'(1);
              erase_addr_q <= erase_addr_q + crcl_pkg::AddrW'(SLOT_BYTES);
            end
          end
          BEAT_TEXT: begin
            text_done_q <= 1'b1;
          end
          default: begin
            close_idx_q <= close_idx_q + 2'd1;
          end
        endcase
      end
    end
  end

  // Hold the output write until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= avail_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_addr_q  <= addr;
      out_byte_q  <= data;
      out_erase_q <= (beat == BEAT_ERASE);
      out_last_q  <= last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign wr_address_o = out_addr_q;
  assign wr_byte_o    = out_byte_q;
  assign is_erase_o   = out_erase_q;
  assign run_last_o   = out_last_q;

endmodule

`default_nettype wire

>>> rtl/core/crc_framed_log_record_writer_unit.sv
// ----------------------------------------------------------------------------
// crc_framed_log_record_writer_unit: CRC framed log record writer
// Message bytes go in on the slave stream (tlast closes a message); one
// EEPROM byte write per beat comes out on the master stream.
//
// Usage:
//   - Each accepted byte may cause no write, one text write, the record
//     close (NUL, CRC high, CRC low) and, at the first byte of a message
//     when the log is full, SLOT_COUNT erase writes ahead of them.
//   - The master tlast marks the last write caused by one input byte;
//     the master tuser flags the slot-clearing erase writes.
//   - The first write of a byte goes through the queue and output register.
//   - Throughput: one byte per cycle while each byte causes at most one
//     write; the write sequencer emits one write per cycle while
//     m_axis_tready allows; a record close is three writes, a wrap-around
//     erase SLOT_COUNT. A four-entry request queue between the classifier
//     and sequencer absorbs these bursts before s_axis_tready drops.
//   - When the receiver holds m_axis_tready low, the output write holds,
//     the queue fills, and then input is stalled.
//   - Reset empties the queue and output stage and starts an empty log
//     at slot 0; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_framed_log_record_writer_unit #(
  parameter int unsigned SLOT_BYTES = 64,
  parameter int unsigned SLOT_COUNT = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] msg_byte
  input  wire logic        s_axis_tlast_i,   // msg_end
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,   // [10:0] wr_address, [18:11] wr_byte,
                                             // [23:19] zero
  output logic             m_axis_tuser_o,   // [0] is_erase
  output logic             m_axis_tlast_o    // run_last
);

  logic                             push, full, pop, avail;
  crcl_pkg::cmd_t                   cmd, head;
  logic [crcl_pkg::AddrW-1:0]       wr_address;
  logic [crcl_pkg::ByteW-1:0]       wr_byte;

  // Classify incoming bytes
  crcl_front #(
    .SLOT_BYTES(SLOT_BYTES),
    .SLOT_COUNT(SLOT_COUNT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .msg_byte_i (s_axis_tdata_i),
    .msg_end_i  (s_axis_tlast_i),
    .push_o     (push),
    .cmd_o      (cmd),
    .full_i     (full)
  );

  // Buffer requests
  crcl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head),
    .avail_o (avail)
  );

  // Sequence memory writes
  crcl_back #(
    .SLOT_BYTES(SLOT_BYTES),
    .SLOT_COUNT(SLOT_COUNT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .avail_i      (avail),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .wr_address_o (wr_address),
    .wr_byte_o    (wr_byte),
    .is_erase_o   (m_axis_tuser_o),
    .run_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {5'h00, wr_byte, wr_address};

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for crc_framed_log_record_writer_unit
// Streams log messages into the slave port and checks every EEPROM write on
// the master port against a cycle-free model of the log: slot addressing,
// text capping, zero-terminated text, NUL plus CRC-16/CCITT-FALSE record
// close, and the slot-clearing erase burst once the log is full.
// ----------------------------------------------------------------------------

module tb;

  localparam int unsigned SLOT_BYTES  = 64;
  localparam int unsigned SLOT_COUNT  = 32;
  localparam int unsigned TEXT_CAP    = (SLOT_BYTES - 3 < crcl_pkg::TextCapMax)
                                        ? SLOT_BYTES - 3 : crcl_pkg::TextCapMax;
  localparam int          ITEM_TARGET = 480;
  localparam int          STALL_LIMIT = 5000;
  localparam int          DIR_ROWS    = 13;

  // One EEPROM byte write as seen on the master stream
  typedef struct packed {
    logic [crcl_pkg::AddrW-1:0] addr;
    logic [crcl_pkg::ByteW-1:0] wbyte;
    logic                       erase;
    logic                       last;
  } eeprom_write_t;

  localparam eeprom_write_t NO_WRITE = '0;

  // Directed request: typed rows carry their expected write (zero or one)
  typedef struct {
    logic [7:0]    b;
    logic          e;
    logic          typed;
    int            n_typed;
    eeprom_write_t w;
  } msg_vector_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;

  // Model state of the log
  logic [crcl_pkg::CountW-1:0] log_entries = '0;
  logic [crcl_pkg::CrcW-1:0]   crc_acc     = crcl_pkg::CrcInit;
  logic [crcl_pkg::LenW-1:0]   kept_len    = '0;
  logic                        msg_open    = 1'b0;
  logic                        text_done   = 1'b0;

  eeprom_write_t writes_due[$];
  eeprom_write_t step_writes[$];

  int snd_idle_pct   = 23;
  int rcv_idle_pct   = 69;
  int errors         = 0;
  int items_sent     = 0;
  int writes_checked = 0;
  int records_closed = 0;
  int erase_bursts   = 0;
  int stall_cycles   = 0;

  msg_vector_t dir_table [DIR_ROWS] = '{
    '{8'h41, 1'b0, 1'b1, 1, '{11'd0,   8'h41, 1'b0, 1'b1}},  // first text byte, slot 0
    '{8'hFF, 1'b0, 1'b1, 1, '{11'd1,   8'hFF, 1'b0, 1'b1}},  // all-ones byte
    '{8'h01, 1'b1, 1'b0, 0, NO_WRITE},                        // close record 0
    '{8'h00, 1'b1, 1'b1, 0, NO_WRITE},                        // empty message
    '{8'h00, 1'b0, 1'b1, 0, NO_WRITE},                        // zero ends text at once
    '{8'h55, 1'b1, 1'b1, 0, NO_WRITE},                        // ignored, still empty
    '{8'h7E, 1'b0, 1'b1, 1, '{11'd64,  8'h7E, 1'b0, 1'b1}},  // slot 1
    '{8'h00, 1'b0, 1'b1, 0, NO_WRITE},                        // zero ends text
    '{8'h33, 1'b1, 1'b0, 0, NO_WRITE},                        // ignored byte, close
    '{8'h80, 1'b1, 1'b0, 0, NO_WRITE},                        // one-byte record
    '{8'hAA, 1'b0, 1'b1, 1, '{11'd192, 8'hAA, 1'b0, 1'b1}},  // slot 3
    '{8'h55, 1'b0, 1'b1, 1, '{11'd193, 8'h55, 1'b0, 1'b1}},
    '{8'h00, 1'b1, 1'b0, 0, NO_WRITE}                         // zero with end: close
  };

  crc_framed_log_record_writer_unit #(
    .SLOT_BYTES(SLOT_BYTES),
    .SLOT_COUNT(SLOT_COUNT)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),   // [7:0] msg_byte
    .s_axis_tlast_i (s_axis_tlast_i),   // msg_end
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),   // [10:0] addr, [18:11] byte
    .m_axis_tuser_o (m_axis_tuser_o),   // [0] erase
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Bitwise CRC-16/CCITT-FALSE step, MSB first
  function automatic logic [crcl_pkg::CrcW-1:0] ccitt_shift_in(
      input logic [crcl_pkg::CrcW-1:0] c,
      input logic [7:0]                d);
    logic [crcl_pkg::CrcW-1:0] r;
    r = c ^ {d, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
    end
    return r;
  endfunction

  // Advance the log model by one accepted request; collect its writes
  task automatic log_writer_step(input logic [7:0] b, input logic e);
    logic [crcl_pkg::AddrW-1:0] base;
    eeprom_write_t              w;
    step_writes.delete();
    if (!msg_open) begin
      msg_open  = 1'b1;
      crc_acc   = crcl_pkg::CrcInit;
      kept_len  = '0;
      text_done = 1'b0;
      if (log_entries >= SLOT_COUNT) begin
        for (int unsigned k = 0; k < SLOT_COUNT; k++) begin
          step_writes.push_back(eeprom_write_t'{crcl_pkg::AddrW'(k * SLOT_BYTES), 8'h00,
                                                1'b1, 1'b0});
        end
        log_entries = '0;
        erase_bursts++;
      end
    end
    if (!text_done) begin
      if (b == 8'h00) begin
        text_done = 1'b1;
      end else if (kept_len < TEXT_CAP) begin
        step_writes.push_back(eeprom_write_t'{
            crcl_pkg::AddrW'(log_entries * SLOT_BYTES + kept_len), b, 1'b0, 1'b0});
        crc_acc  = ccitt_shift_in(crc_acc, b);
        kept_len = kept_len + 1'b1;
      end
    end
    // Close the record: NUL, then CRC high and low byte
    if (e) begin
      if (kept_len != 0) begin
        base    = crcl_pkg::AddrW'(log_entries * SLOT_BYTES + kept_len);
        crc_acc = ccitt_shift_in(crc_acc, 8'h00);
        step_writes.push_back(eeprom_write_t'{base,        8'h00,         1'b0, 1'b0});
        step_writes.push_back(eeprom_write_t'{base + 1'b1, crc_acc[15:8], 1'b0, 1'b0});
        step_writes.push_back(eeprom_write_t'{base + 2'd2, crc_acc[7:0],  1'b0, 1'b0});
        log_entries = log_entries + 1'b1;
        records_closed++;
      end
      msg_open  = 1'b0;
      text_done = 1'b0;
      kept_len  = '0;
      crc_acc   = crcl_pkg::CrcInit;
    end
    if (step_writes.size() > 0) begin
      w = step_writes.pop_back();
      w.last = 1'b1;
      step_writes.push_back(w);
    end
  endtask

  // Offer one request, wait for accept, then queue its expected writes
  task automatic push_msg_byte(input logic [7:0] b, input logic e, input logic typed,
                               input int n_typed, input eeprom_write_t tw);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= e;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    items_sent++;
    log_writer_step(b, e);
    if (typed) begin
      if (n_typed > 0) writes_due.push_back(tw);
    end else begin
      foreach (step_writes[k]) writes_due.push_back(step_writes[k]);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic e);
    push_msg_byte(b, e, 1'b0, 0, NO_WRITE);
  endtask

  // Hold the sender until every expected write has come out
  task automatic drain_writes();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (writes_due.size() != 0) @(posedge clk_i);
  endtask

  // Receiver back-pressure
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Check each accepted write against the oldest expectation
  always @(posedge clk_i) begin : write_check
    eeprom_write_t exp_w;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      writes_checked++;
      if (writes_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected write addr %h byte %h erase %b last %b", $time,
                 m_axis_tdata_o[10:0], m_axis_tdata_o[18:11], m_axis_tuser_o,
                 m_axis_tlast_o);
      end else begin
        exp_w = writes_due.pop_front();
        if (m_axis_tdata_o[10:0] !== exp_w.addr) begin
          errors++;
          $display("%0t: wr_address expected %h got %h", $time, exp_w.addr,
                   m_axis_tdata_o[10:0]);
        end
        if (m_axis_tdata_o[18:11] !== exp_w.wbyte) begin
          errors++;
          $display("%0t: wr_byte expected %h got %h", $time, exp_w.wbyte,
                   m_axis_tdata_o[18:11]);
        end
        if (m_axis_tuser_o !== exp_w.erase) begin
          errors++;
          $display("%0t: is_erase expected %b got %b", $time, exp_w.erase,
                   m_axis_tuser_o);
        end
        if (m_axis_tlast_o !== exp_w.last) begin
          errors++;
          $display("%0t: run_last expected %b got %b", $time, exp_w.last,
                   m_axis_tlast_o);
        end
      end
    end
  end

  // Watchdog: give up after a long stretch with no transfer on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d writes outstanding", $time,
                 STALL_LIMIT, writes_due.size());
        $display("tb failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : main
    int   kind;
    int   len;
    int   zero_at;
    int   phase;
    logic first_msg;
    logic wrap_empty_done;

    phase           = 0;
    first_msg       = 1'b1;
    wrap_empty_done = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests
    for (int i = 0; i < DIR_ROWS; i++) begin
      push_msg_byte(dir_table[i].b, dir_table[i].e, dir_table[i].typed,
                    dir_table[i].n_typed, dir_table[i].w);
    end
    drain_writes();

    // Random messages, one message per pass
    while (items_sent < ITEM_TARGET) begin
      // Swap idling roles, then drop idling, each after a full drain
      if (phase == 0 && items_sent >= ITEM_TARGET / 3) begin
        drain_writes();
        phase        = 1;
        snd_idle_pct = 69;
        rcv_idle_pct = 23;
      end else if (phase == 1 && items_sent >= 2 * ITEM_TARGET / 3) begin
        drain_writes();
        phase        = 2;
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end

      kind = $urandom_range(99);
      if (first_msg) begin
        // Long text past the cap
        first_msg = 1'b0;
        for (int j = 0; j < 66; j++) send_byte(8'($urandom_range(1, 255)), j == 65);
      end else if (!wrap_empty_done && log_entries >= SLOT_COUNT) begin
        // Full log met by an empty message: erase still happens
        wrap_empty_done = 1'b1;
        send_byte(8'h00, 1'b1);
      end else if (kind < 6) begin
        // Text ended before it starts, noise after
        len = $urandom_range(1, 4);
        send_byte(8'h00, len == 1);
        for (int j = 1; j < len; j++) send_byte(8'($urandom_range(255)), j == len - 1);
      end else if (kind < 14) begin
        len = $urandom_range(62, 72);
        for (int j = 0; j < len; j++) send_byte(8'($urandom_range(1, 255)), j == len - 1);
      end else if (kind < 24) begin
        // Zero in the middle, arbitrary bytes after
        len     = $urandom_range(2, 10);
        zero_at = $urandom_range(1, len - 1);
        for (int j = 0; j < len; j++) begin
          send_byte((j == zero_at) ? 8'h00 : 8'($urandom_range(255)), j == len - 1);
        end
      end else begin
        len = $urandom_range(1, 12);
        if ($urandom_range(99) < 30) begin
          for (int j = 0; j < len; j++) send_byte(8'($urandom_range(1, 255)), 1'b0);
          send_byte(8'h00, 1'b1);
        end else begin
          for (int j = 0; j < len; j++) send_byte(8'($urandom_range(1, 255)), j == len - 1);
        end
      end
    end

    drain_writes();
    repeat (20) @(posedge clk_i);

    $display("Sent %0d message bytes, checked %0d EEPROM writes", items_sent, writes_checked);
    $display("Closed %0d records, saw %0d full-log erase bursts", records_closed,
             erase_bursts);
    if (errors == 0 && writes_due.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/crcl_pkg.sv
rtl/core/crcl_front.sv
rtl/core/crcl_queue.sv
rtl/core/crcl_back.sv
rtl/core/crc_framed_log_record_writer_unit.sv
sim/tb.sv
